// ===== rtl/io_range_overlap_scoreboard_defines.svh =====
// Assertion macros used by the checker file of the scoreboard.
`ifndef IO_RANGE_OVERLAP_SCOREBOARD_DEFINES_SVH
`define IO_RANGE_OVERLAP_SCOREBOARD_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IORS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scoreboard check failed");

// The consequent must hold in the cycle after the antecedent.
`define IORS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scoreboard check failed");

`endif

// ===== rtl/iors_pkg.sv =====
`default_nettype none

package iors_pkg;

    localparam int TABLE_DEPTH_DEF = 32;
    localparam int SECTOR_BITS_DEF = 48;
    localparam int LENGTH_BITS_DEF = 16;

    localparam int HANDLE_W = 5;
    localparam int CNT_W    = 5;
    localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;
    localparam int RSP_W    = 16;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_DELETE = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        KIND_INSERT  = 2'd0,
        KIND_DELETE  = 2'd1,
        KIND_RELEASE = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FULL = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DRD,
        S_DCHK,
        S_SCAN,
        S_IWR,
        S_ANS,
        S_REL
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/iors_ifs.sv =====
`default_nettype none

interface iors_req_if #(
    parameter int SECTOR_BITS = iors_pkg::SECTOR_BITS_DEF,
    parameter int LENGTH_BITS = iors_pkg::LENGTH_BITS_DEF
);
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [SECTOR_BITS-1:0]        start_sector;
    logic [LENGTH_BITS-1:0]        sector_count;
    logic [iors_pkg::HANDLE_W-1:0] handle;

    modport source (output valid, func, start_sector, sector_count, handle, input ready);
    modport sink   (input valid, func, start_sector, sector_count, handle, output ready);
endinterface

interface iors_rsp_if;
    logic                       valid;
    logic                       ready;
    iors_pkg::t_kind            kind;
    iors_pkg::t_status          status;
    logic [iors_pkg::HANDLE_W-1:0] slot;
    logic [iors_pkg::CNT_W-1:0] overlap_count;
    logic                       delayed;
    logic                       last;

    modport source (output valid, kind, status, slot, overlap_count, delayed, last,
                    input ready);
    modport sink   (input valid, kind, status, slot, overlap_count, delayed, last,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/iors_entry_ram.sv =====
`default_nettype none

module iors_entry_ram #(
    parameter int DEPTH = iors_pkg::TABLE_DEPTH_DEF,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== rtl/iors_overlap_cmp.sv =====
`default_nettype none

module iors_overlap_cmp #(
    parameter int SB = iors_pkg::SECTOR_BITS_DEF,
    parameter int EW = SB + 1
) (
    input  wire logic [SB-1:0] i_a_start,
    input  wire logic [EW-1:0] i_a_end,
    input  wire logic [SB-1:0] i_b_start,
    input  wire logic [EW-1:0] i_b_end,
    output logic               o_meet
);

    logic [EW-1:0] a_start_x;
    logic [EW-1:0] b_start_x;

    assign a_start_x = EW'(i_a_start);
    assign b_start_x = EW'(i_b_start);

    // An empty range ends where it starts and overlaps nothing.
    assign o_meet = (i_a_end != a_start_x) && (i_b_end != b_start_x)
                    && (a_start_x < i_b_end) && (b_start_x < i_a_end);

endmodule

`default_nettype wire

// ===== rtl/io_range_overlap_scoreboard.sv =====
// Insert: the table is scanned, the range is stored if a slot is free, then it is answered.
// Delete: entry checked; if it may go, table scanned; answer, then releases in slot order.
// The table is walked one slot per cycle through the single read port of the entry RAM.
// One transaction is in progress at a time; the input is not ready until it has finished.
// Reset (synchronous, active low) empties the table at once and drops any pending result.
`default_nettype none

module io_range_overlap_scoreboard #(
    parameter int TABLE_DEPTH = iors_pkg::TABLE_DEPTH_DEF,
    parameter int SECTOR_BITS = iors_pkg::SECTOR_BITS_DEF,
    parameter int LENGTH_BITS = iors_pkg::LENGTH_BITS_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    iors_req_if.sink    i_req,
    iors_rsp_if.source  o_rsp
);

    localparam int IW  = $clog2(TABLE_DEPTH);
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int HW  = iors_pkg::HANDLE_W;
    localparam int NW  = iors_pkg::CNT_W;
    localparam int EW  = ((SECTOR_BITS > LENGTH_BITS) ? SECTOR_BITS : LENGTH_BITS) + 1;
    localparam int RW  = SECTOR_BITS + EW + NW;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    iors_pkg::t_state r_state, n_state;

    iors_pkg::t_func        r_func, n_func;
    logic [SECTOR_BITS-1:0] r_pos, n_pos;
    logic [EW-1:0]          r_end, n_end;
    logic [HW-1:0]          r_hraw, n_hraw;
    logic                   r_hok, n_hok;
    logic [CW-1:0]          r_idx, n_idx;
    logic [IW-1:0]          r_pidx, n_pidx;
    logic                   r_pv, n_pv;
    logic                   r_found, n_found;
    logic [IW-1:0]          r_free, n_free;
    logic [NW-1:0]          r_cnt, n_cnt;
    logic [NW-1:0]          r_emit, n_emit;
    logic                   r_bad, n_bad;
    logic [TABLE_DEPTH-1:0] r_mask, n_mask;
    logic [TABLE_DEPTH-1:0] r_valid, n_valid;

    logic                   r_out_valid, n_out_valid;
    iors_pkg::t_kind        r_out_kind, n_out_kind;
    iors_pkg::t_status      r_out_status, n_out_status;
    logic [HW-1:0]          r_out_slot, n_out_slot;
    logic [NW-1:0]          r_out_cnt, n_out_cnt;
    logic                   r_out_delayed, n_out_delayed;
    logic                   r_out_last, n_out_last;

    logic                   ram_we;
    logic [IW-1:0]          ram_waddr;
    logic [RW-1:0]          ram_wdata;
    logic [IW-1:0]          ram_raddr;
    logic [RW-1:0]          ram_rdata;

    logic [SECTOR_BITS-1:0] rd_start;
    logic [EW-1:0]          rd_end;
    logic [NW-1:0]          rd_cnt;
    logic [NW-1:0]          rd_cnt_dec;
    logic                   meet;
    logic                   in_acc;
    logic                   out_free;
    logic                   scan_done;
    logic                   entry_valid;
    logic [IW-1:0]          h_idx;
    logic [IW+HW-1:0]       h_wide;
    logic [HW-1:0]          free_slot;
    logic [IW+HW-1:0]       free_wide;
    logic [HW-1:0]          rel_slot;
    logic [CW+HW-1:0]       rel_wide;

    assign {rd_start, rd_end, rd_cnt} = ram_rdata;
    assign rd_cnt_dec = rd_cnt - NW'(1);

    assign h_wide    = (IW+HW)'(r_hraw);
    assign h_idx     = h_wide[IW-1:0];
    assign free_wide = (IW+HW)'(r_free);
    assign free_slot = free_wide[HW-1:0];
    assign rel_wide  = (CW+HW)'(r_idx);
    assign rel_slot  = rel_wide[HW-1:0];

    assign in_acc      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign scan_done   = r_pv && (r_pidx == LAST_IDX);
    assign entry_valid = r_valid[r_pidx];

    iors_entry_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (RW),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    iors_overlap_cmp #(
        .SB (SECTOR_BITS),
        .EW (EW)
    ) u_cmp (
        .i_a_start (r_pos),
        .i_a_end   (r_end),
        .i_b_start (rd_start),
        .i_b_end   (rd_end),
        .o_meet    (meet)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            iors_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_req.func == iors_pkg::FUNC_DELETE) ? iors_pkg::S_DRD
                                                                    : iors_pkg::S_SCAN;
                end
            end
            iors_pkg::S_DRD: begin
                n_state = iors_pkg::S_DCHK;
            end
            iors_pkg::S_DCHK: begin
                if (!r_hok || !r_valid[h_idx] || (rd_cnt != '0)) begin
                    n_state = iors_pkg::S_ANS;
                end else begin
                    n_state = iors_pkg::S_SCAN;
                end
            end
            iors_pkg::S_SCAN: begin
                if (scan_done) begin
                    n_state = (r_func == iors_pkg::FUNC_INSERT) ? iors_pkg::S_IWR
                                                                : iors_pkg::S_ANS;
                end
            end
            iors_pkg::S_IWR: begin
                n_state = iors_pkg::S_ANS;
            end
            iors_pkg::S_ANS: begin
                if (out_free) begin
                    if ((r_func == iors_pkg::FUNC_DELETE) && !r_bad && (r_cnt != '0)) begin
                        n_state = iors_pkg::S_REL;
                    end else begin
                        n_state = iors_pkg::S_IDLE;
                    end
                end
            end
            iors_pkg::S_REL: begin
                if (r_mask[0] && out_free && (r_emit + NW'(1) == r_cnt)) begin
                    n_state = iors_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = iors_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        i_req.ready   = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = r_pidx;
        ram_wdata     = {rd_start, rd_end, rd_cnt_dec};
        ram_raddr     = r_idx[IW-1:0];

        n_func        = r_func;
        n_pos         = r_pos;
        n_end         = r_end;
        n_hraw        = r_hraw;
        n_hok         = r_hok;
        n_idx         = r_idx;
        n_pidx        = r_pidx;
        n_pv          = r_pv;
        n_found       = r_found;
        n_free        = r_free;
        n_cnt         = r_cnt;
        n_emit        = r_emit;
        n_bad         = r_bad;
        n_mask        = r_mask;
        n_valid       = r_valid;

        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_out_kind    = r_out_kind;
        n_out_status  = r_out_status;
        n_out_slot    = r_out_slot;
        n_out_cnt     = r_out_cnt;
        n_out_delayed = r_out_delayed;
        n_out_last    = r_out_last;

        unique case (r_state)
            iors_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
                if (in_acc) begin
                    n_func  = iors_pkg::t_func'(i_req.func);
                    n_pos   = i_req.start_sector;
                    n_end   = EW'(i_req.start_sector) + EW'(i_req.sector_count);
                    n_hraw  = i_req.handle;
                    n_hok   = (32'(i_req.handle) < TABLE_DEPTH);
                    n_idx   = '0;
                    n_pv    = 1'b0;
                    n_found = 1'b0;
                    n_cnt   = '0;
                    n_bad   = 1'b0;
                end
            end
            iors_pkg::S_DRD: begin
                ram_raddr = h_idx;
            end
            iors_pkg::S_DCHK: begin
                if (!r_hok || !r_valid[h_idx] || (rd_cnt != '0)) begin
                    n_bad = 1'b1;
                end else begin
                    n_pos          = rd_start;
                    n_end          = rd_end;
                    n_valid[h_idx] = 1'b0;
                end
            end
            iors_pkg::S_SCAN: begin
                ram_raddr = r_idx[IW-1:0];
                n_pv      = (32'(r_idx) < TABLE_DEPTH);
                n_pidx    = r_idx[IW-1:0];
                if (32'(r_idx) < TABLE_DEPTH) begin
                    n_idx = r_idx + CW'(1);
                end
                if (r_pv) begin
                    if (r_func == iors_pkg::FUNC_INSERT) begin
                        n_mask = {1'b0, r_mask[TABLE_DEPTH-1:1]};
                        if (entry_valid && meet && (r_cnt != iors_pkg::CNT_MAX)) begin
                            n_cnt = r_cnt + NW'(1);
                        end
                        if (!entry_valid && !r_found) begin
                            n_found = 1'b1;
                            n_free  = r_pidx;
                        end
                    end else begin
                        n_mask = {1'b0, r_mask[TABLE_DEPTH-1:1]};
                        if (entry_valid && meet && (rd_cnt != '0)) begin
                            ram_we = 1'b1;
                            if ((rd_cnt_dec == '0) && (r_cnt != iors_pkg::CNT_MAX)) begin
                                n_mask = {1'b1, r_mask[TABLE_DEPTH-1:1]};
                                n_cnt  = r_cnt + NW'(1);
                            end
                        end
                    end
                end
            end
            iors_pkg::S_IWR: begin
                if (r_found) begin
                    ram_we          = 1'b1;
                    ram_waddr       = r_free;
                    ram_wdata       = {r_pos, r_end, r_cnt};
                    n_valid[r_free] = 1'b1;
                end
            end
            iors_pkg::S_ANS: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_idx       = '0;
                    n_emit      = '0;
                    if (r_func == iors_pkg::FUNC_INSERT) begin
                        n_out_kind    = iors_pkg::KIND_INSERT;
                        n_out_status  = r_found ? iors_pkg::ST_OK : iors_pkg::ST_FULL;
                        n_out_slot    = r_found ? free_slot : '0;
                        n_out_cnt     = r_found ? r_cnt : '0;
                        n_out_delayed = r_found && (r_cnt != '0);
                        n_out_last    = 1'b1;
                    end else begin
                        n_out_kind    = iors_pkg::KIND_DELETE;
                        n_out_status  = r_bad ? iors_pkg::ST_BAD : iors_pkg::ST_OK;
                        n_out_slot    = r_hraw;
                        n_out_cnt     = r_bad ? '0 : r_cnt;
                        n_out_delayed = 1'b0;
                        n_out_last    = r_bad || (r_cnt == '0);
                    end
                end
            end
            iors_pkg::S_REL: begin
                if (!r_mask[0] || out_free) begin
                    n_mask = {1'b0, r_mask[TABLE_DEPTH-1:1]};
                    n_idx  = r_idx + CW'(1);
                end
                if (r_mask[0] && out_free) begin
                    n_emit        = r_emit + NW'(1);
                    n_out_valid   = 1'b1;
                    n_out_kind    = iors_pkg::KIND_RELEASE;
                    n_out_status  = iors_pkg::ST_OK;
                    n_out_slot    = rel_slot;
                    n_out_cnt     = '0;
                    n_out_delayed = 1'b0;
                    n_out_last    = (r_emit + NW'(1) == r_cnt);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= iors_pkg::S_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func        <= n_func;
        r_pos         <= n_pos;
        r_end         <= n_end;
        r_hraw        <= n_hraw;
        r_hok         <= n_hok;
        r_idx         <= n_idx;
        r_pidx        <= n_pidx;
        r_pv          <= n_pv;
        r_found       <= n_found;
        r_free        <= n_free;
        r_cnt         <= n_cnt;
        r_emit        <= n_emit;
        r_bad         <= n_bad;
        r_mask        <= n_mask;
        r_out_kind    <= n_out_kind;
        r_out_status  <= n_out_status;
        r_out_slot    <= n_out_slot;
        r_out_cnt     <= n_out_cnt;
        r_out_delayed <= n_out_delayed;
        r_out_last    <= n_out_last;
    end

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.kind          = r_out_kind;
    assign o_rsp.status        = r_out_status;
    assign o_rsp.slot          = r_out_slot;
    assign o_rsp.overlap_count = r_out_cnt;
    assign o_rsp.delayed       = r_out_delayed;
    assign o_rsp.last          = r_out_last;

endmodule

`default_nettype wire

// ===== rtl/iors_checker.sv =====
`default_nettype none

`include "io_range_overlap_scoreboard_defines.svh"

module iors_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       i_req_valid,
    input wire logic                       i_req_ready,
    input wire logic                       i_rsp_valid,
    input wire logic                       i_rsp_ready,
    input wire logic                       i_rsp_last,
    input wire logic [iors_pkg::RSP_W-1:0] i_rsp_data
);

    // Only one transaction is worked on at a time.
    `IORS_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)

    // A result that is not the last of its transaction keeps the input closed.
    `IORS_ASSERT_SAME(a_more_pending, i_clk, i_rst_n, i_rsp_valid && !i_rsp_last, !i_req_ready)

    `IORS_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_data))

endmodule

bind io_range_overlap_scoreboard iors_checker u_iors_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_last  (o_rsp.last),
    .i_rsp_data  ({o_rsp.kind, o_rsp.status, o_rsp.slot, o_rsp.overlap_count,
                   o_rsp.delayed, o_rsp.last})
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
module tb;

    localparam int CLK_PERIOD     = 12;
    localparam int DEPTH          = iors_pkg::TABLE_DEPTH_DEF;
    localparam int SB             = iors_pkg::SECTOR_BITS_DEF;
    localparam int LB             = iors_pkg::LENGTH_BITS_DEF;
    localparam int HW             = iors_pkg::HANDLE_W;
    localparam int CW             = iors_pkg::CNT_W;
    localparam int TIMEOUT_CYCLES = 2_000_000;
    localparam int DRAIN_LIMIT    = 200_000;

    typedef struct {
        iors_pkg::t_kind     kind;
        iors_pkg::t_status   status;
        logic [HW-1:0]       slot;
        logic [CW-1:0]       overlap_count;
        logic                delayed;
        logic                last;
    } t_answer;

    logic i_clk = 1'b0;
    logic i_rst_n;

    iors_req_if req_if ();
    iors_rsp_if rsp_if ();

    io_range_overlap_scoreboard i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    logic                tbl_valid [DEPTH];
    logic [SB-1:0]       tbl_start [DEPTH];
    logic [LB-1:0]       tbl_len   [DEPTH];
    logic [CW-1:0]       tbl_wait  [DEPTH];

    t_answer awaited_answers [$];

    int  mismatches         = 0;
    int  items_sent         = 0;
    int  sender_idle_pct    = 0;
    int  receiver_stall_pct = 0;
    int  hold_cycles        = 0;
    bit  hold_active        = 1'b0;
    event hold_go;

    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("FAIL io_range_overlap_scoreboard");
        $finish;
    end

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    function automatic bit sectors_overlap(logic [SB-1:0] a, logic [LB-1:0] la,
                                           logic [SB-1:0] b, logic [LB-1:0] lb);
        if (la == '0 || lb == '0) begin
            return 1'b0;
        end
        return (64'(a) < 64'(b) + 64'(lb)) && (64'(b) < 64'(a) + 64'(la));
    endfunction

    function automatic void predict_answers(iors_pkg::t_func f, logic [SB-1:0] s,
                                            logic [LB-1:0] n, logic [HW-1:0] h);
        t_answer          released [$];
        int               free_slot;
        logic [CW-1:0]    cnt;
        free_slot = -1;
        cnt       = '0;
        if (f == iors_pkg::FUNC_INSERT) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (!tbl_valid[i] && free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (free_slot < 0) begin
                awaited_answers.push_back('{iors_pkg::KIND_INSERT, iors_pkg::ST_FULL, '0, '0,
                                            1'b0, 1'b1});
            end else begin
                for (int i = 0; i < DEPTH; i++) begin
                    if (tbl_valid[i] && sectors_overlap(s, n, tbl_start[i], tbl_len[i])
                            && cnt < iors_pkg::CNT_MAX) begin
                        cnt = cnt + 1'b1;
                    end
                end
                tbl_valid[free_slot] = 1'b1;
                tbl_start[free_slot] = s;
                tbl_len[free_slot]   = n;
                tbl_wait[free_slot]  = cnt;
                awaited_answers.push_back('{iors_pkg::KIND_INSERT, iors_pkg::ST_OK,
                                            HW'(free_slot), cnt, cnt != '0, 1'b1});
            end
        end else if (!tbl_valid[h] || tbl_wait[h] != '0) begin
            awaited_answers.push_back('{iors_pkg::KIND_DELETE, iors_pkg::ST_BAD, h, '0,
                                        1'b0, 1'b1});
        end else begin
            tbl_valid[h] = 1'b0;
            for (int i = 0; i < DEPTH; i++) begin
                if (tbl_valid[i] && tbl_wait[i] != '0
                        && sectors_overlap(tbl_start[h], tbl_len[h], tbl_start[i], tbl_len[i]))
                begin
                    tbl_wait[i] = tbl_wait[i] - 1'b1;
                    if (tbl_wait[i] == '0 && released.size() < int'(iors_pkg::CNT_MAX)) begin
                        released.push_back('{iors_pkg::KIND_RELEASE, iors_pkg::ST_OK, HW'(i),
                                             '0, 1'b0, 1'b0});
                    end
                end
            end
            awaited_answers.push_back('{iors_pkg::KIND_DELETE, iors_pkg::ST_OK, h,
                                        CW'(released.size()), 1'b0, released.size() == 0});
            if (released.size() != 0) begin
                released[released.size() - 1].last = 1'b1;
            end
            foreach (released[i]) begin
                awaited_answers.push_back(released[i]);
            end
        end
    endfunction

    function automatic int deletable_slot();
        int picks [$];
        for (int i = 0; i < DEPTH; i++) begin
            if (tbl_valid[i] && tbl_wait[i] == '0) begin
                picks.push_back(i);
            end
        end
        if (picks.size() == 0) begin
            return -1;
        end
        return picks[$urandom_range(picks.size() - 1)];
    endfunction

    function automatic logic [SB-1:0] any_sector();
        return SB'({$urandom(), $urandom()});
    endfunction

    task automatic send_item(iors_pkg::t_func f, logic [SB-1:0] s, logic [LB-1:0] n,
                             logic [HW-1:0] h);
        if ($urandom_range(99) < sender_idle_pct) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 45)) @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.func         <= f;
        req_if.start_sector <= s;
        req_if.sector_count <= n;
        req_if.handle       <= h;
        @(posedge i_clk);
        while (!req_if.ready) begin
            @(posedge i_clk);
        end
        predict_answers(f, s, n, h);
        items_sent++;
    endtask

    task automatic drain_table();
        int slot;
        slot = deletable_slot();
        while (slot >= 0) begin
            send_item(iors_pkg::FUNC_DELETE, any_sector(), LB'($urandom()), HW'(slot));
            slot = deletable_slot();
        end
    endtask

    task automatic run_episode(int n_items);
        logic [SB-1:0] base;
        logic [63:0]   span;
        logic [63:0]   offset;
        int            len_hi;
        int            insert_pct;
        int            slot;
        logic [LB-1:0] n;
        base = any_sector();
        case ($urandom_range(3))
            0: begin
                span = 64;
            end
            1: begin
                span = 4096;
            end
            2: begin
                span = 64'd1 << 20;
            end
            default: begin
                span = 64'd1 << SB;
            end
        endcase
        case ($urandom_range(2))
            0: begin
                len_hi = 16;
            end
            1: begin
                len_hi = 4096;
            end
            default: begin
                len_hi = 65535;
            end
        endcase
        insert_pct = $urandom_range(40, 85);
        repeat (n_items) begin
            slot = deletable_slot();
            if ($urandom_range(99) < insert_pct || slot < 0) begin
                offset = {$urandom(), $urandom()} % span;
                n = ($urandom_range(19) == 0) ? '0 : LB'($urandom_range(1, len_hi));
                send_item(iors_pkg::FUNC_INSERT, SB'(64'(base) + offset), n, HW'($urandom()));
            end else if ($urandom_range(9) == 0) begin
                send_item(iors_pkg::FUNC_DELETE, any_sector(), LB'($urandom()), HW'($urandom()));
            end else begin
                send_item(iors_pkg::FUNC_DELETE, any_sector(), LB'($urandom()), HW'(slot));
            end
        end
    endtask

    task automatic test_directed();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        send_item(iors_pkg::FUNC_INSERT, '0, LB'(1), '0);
        send_item(iors_pkg::FUNC_INSERT, '1, '1, '0);
        send_item(iors_pkg::FUNC_INSERT, '0, '1, '0);
        send_item(iors_pkg::FUNC_INSERT, 48'hFFFF_FFFF_0000, '1, '0);
        send_item(iors_pkg::FUNC_INSERT, 48'hFFFF_FFFF_FFFE, LB'(2), '0);
        send_item(iors_pkg::FUNC_INSERT, SB'(10), '0, '0);
        send_item(iors_pkg::FUNC_INSERT, '0, '1, '0);
        send_item(iors_pkg::FUNC_DELETE, '0, '0, HW'(2));
        send_item(iors_pkg::FUNC_DELETE, '0, '0, HW'(20));
        send_item(iors_pkg::FUNC_DELETE, '0, '0, HW'(5));
        send_item(iors_pkg::FUNC_DELETE, '0, '0, HW'(0));
        send_item(iors_pkg::FUNC_DELETE, '0, '0, HW'(2));
        send_item(iors_pkg::FUNC_DELETE, '0, '0, HW'(1));
        send_item(iors_pkg::FUNC_DELETE, '0, '0, HW'(3));
        send_item(iors_pkg::FUNC_DELETE, '1, '1, HW'(4));
        send_item(iors_pkg::FUNC_DELETE, '1, '1, HW'(6));
        send_item(iors_pkg::FUNC_DELETE, '1, '1, '1);
        send_item(iors_pkg::FUNC_INSERT, SB'(100), LB'(100), '1);
        send_item(iors_pkg::FUNC_INSERT, SB'(150), LB'(10), '0);
        send_item(iors_pkg::FUNC_INSERT, SB'(190), LB'(5), '0);
        send_item(iors_pkg::FUNC_INSERT, SB'(120), LB'(60), '0);
        send_item(iors_pkg::FUNC_DELETE, '0, '0, HW'(0));
        send_item(iors_pkg::FUNC_DELETE, '0, '0, HW'(1));
        drain_table();
    endtask

    // Every range covers the sector at base + 255, so the counts climb to the
    // ceiling before the table runs out of slots.
    task automatic test_full_table();
        logic [SB-1:0] base;
        sender_idle_pct    = 27;
        receiver_stall_pct = 27;
        base         = any_sector();
        base[SB-1]   = 1'b0;
        repeat (DEPTH + 2) begin
            send_item(iors_pkg::FUNC_INSERT, base + SB'($urandom_range(255)),
                      LB'($urandom_range(256, 65535)), HW'($urandom()));
        end
        send_item(iors_pkg::FUNC_DELETE, any_sector(), LB'($urandom()), HW'(DEPTH - 1));
        drain_table();
    endtask

    task automatic test_random_phases();
        int phase_start;
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 0;
                end
                1: begin
                    sender_idle_pct    = 68;
                    receiver_stall_pct = 0;
                end
                2: begin
                    sender_idle_pct    = 0;
                    receiver_stall_pct = 68;
                end
                default: begin
                    sender_idle_pct    = 27;
                    receiver_stall_pct = 27;
                end
            endcase
            phase_start = items_sent;
            while (items_sent - phase_start < 60) begin
                run_episode($urandom_range(10, 30));
            end
        end
        drain_table();
    endtask

    task automatic test_receiver_hold_off();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_cycles        = 600;
        -> hold_go;
        run_episode(16);
        drain_table();
    endtask

    always begin : receiver_hold
        @(hold_go);
        @(negedge i_clk);
        hold_active = 1'b1;
        repeat (hold_cycles) @(negedge i_clk);
        hold_active = 1'b0;
    end

    always @(posedge i_clk) begin
        rsp_if.ready <= !hold_active && ($urandom_range(99) >= receiver_stall_pct);
    end

    task automatic check_field(string name, int got, int want);
        if (got != want) begin
            report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
        end
    endtask

    always @(posedge i_clk) begin : check_answers
        t_answer want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (awaited_answers.size() == 0) begin
                report_mismatch("transaction on the response channel with nothing expected");
            end else begin
                want = awaited_answers.pop_front();
                check_field("kind", rsp_if.kind, want.kind);
                check_field("status", rsp_if.status, want.status);
                check_field("slot", rsp_if.slot, want.slot);
                check_field("overlap_count", rsp_if.overlap_count, want.overlap_count);
                check_field("delayed", rsp_if.delayed, want.delayed);
                check_field("last", rsp_if.last, want.last);
            end
        end
    end

    initial begin : run_tests
        int guard;
        foreach (tbl_valid[i]) begin
            tbl_valid[i] = 1'b0;
        end
        req_if.valid        = 1'b0;
        req_if.func         = iors_pkg::FUNC_INSERT;
        req_if.start_sector = '0;
        req_if.sector_count = '0;
        req_if.handle       = '0;
        rsp_if.ready        = 1'b0;
        i_rst_n             = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_full_table();
        test_random_phases();
        test_receiver_hold_off();

        req_if.valid <= 1'b0;
        guard = 0;
        while (awaited_answers.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (DEPTH + 8) @(posedge i_clk);
        if (awaited_answers.size() != 0) begin
            report_mismatch($sformatf("%0d expected results never arrived",
                                      awaited_answers.size()));
        end
        if (mismatches == 0) begin
            $display("PASS io_range_overlap_scoreboard");
        end else begin
            $display("FAIL io_range_overlap_scoreboard");
        end
        $finish;
    end

endmodule
